>>> hw/rtl/fbfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-block free-list allocator.
// No dependencies; imported by every module of the block except fbfl_ram.
package fbfl_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int MAX_COUNT      = 1024;

  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int SIZE_W     = 17;
  localparam int ADDR_W     = 32;
  localparam int LINK_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = INDEX_W + SIZE_W;

  localparam logic [LINK_W-1:0]  END_MARK  = '1;
  localparam logic [COUNT_W-1:0] USED_MAX  = '1;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 17'd64;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic clr_write;  // write one link entry of the rebuild pass
    logic exec_done;  // finish the item, load the result register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_wr;   // block_count written, rebuild restarts
    logic clr_last;   // current rebuild entry is the last block
    logic out_free;   // result register can take a new item
  } dp_status_t;

endpackage

>>> hw/rtl/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg, fbfl_ctrl, fbfl_dpath (which holds fbfl_ram).
//
// Pool allocator for equal-size blocks kept as a LIFO free list in a link RAM.
// Each item (allocate or free) is accepted in the idle state, where the accept
// cycle reads the head's link from the registered-read RAM; the execute state
// then, once the result register is free, moves the head and loads the result
// register. No new item is taken until the last one has loaded its result. A
// result waiting under stall holds one item in the result register; a second
// item is accepted and waits in its execute state. After reset and after every
// write of block_count the list is rebuilt by a pass over block_count entries
// (one link entry per cycle) during which no item is accepted; configuration
// writes are always taken. An allocate on an empty list reports status 1; a
// free of an index not below block_count reports status 2. Double frees are not detected.
module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            mode,
  input  logic [fbfl_pkg::INDEX_W-1:0]    free_index,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [1:0]                      status,
  output logic [fbfl_pkg::INDEX_W-1:0]    block_index,
  output logic [fbfl_pkg::ADDR_W-1:0]     address,
  output logic [fbfl_pkg::COUNT_W-1:0]    used_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbfl_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbfl_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .free_index  (free_index),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .block_index (block_index),
    .address     (address),
    .used_count  (used_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

>>> hw/rtl/fbfl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/fbfl_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences list rebuild, item accept and result hand-off.
// Depends on fbfl_pkg.
module fbfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  fbfl_pkg::dp_status_t sts,
  output fbfl_pkg::ctl_cmd_t   cmd
);
  import fbfl_pkg::*;

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (sts.count_wr) begin
      state_next = FSM_CLEAR;
    end else begin
      unique case (state)
        FSM_CLEAR: if (sts.clr_last) state_next = FSM_IDLE;
        FSM_IDLE:  if (req_valid) state_next = FSM_EXEC;
        FSM_EXEC:  if (sts.out_free) state_next = FSM_IDLE;
        default:   state_next = FSM_CLEAR;
      endcase
    end
  end

  always_comb begin
    req_stall     = 1'b1;
    cmd.accept    = 1'b0;
    cmd.clr_write = 1'b0;
    cmd.exec_done = 1'b0;
    unique case (state)
      FSM_CLEAR: cmd.clr_write = 1'b1;
      FSM_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
      end
      FSM_EXEC:  cmd.exec_done = sts.out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/fbfl_dpath.sv
`timescale 1ns / 1ps
// Datapath: config registers, link RAM, head and used count, address math,
// result register. Depends on fbfl_pkg and fbfl_ram.
module fbfl_dpath #(
  parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fbfl_pkg::ctl_cmd_t                cmd,
  output fbfl_pkg::dp_status_t              sts,
  input  logic                              mode,
  input  logic [fbfl_pkg::INDEX_W-1:0]      free_index,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        status,
  output logic [fbfl_pkg::INDEX_W-1:0]      block_index,
  output logic [fbfl_pkg::ADDR_W-1:0]       address,
  output logic [fbfl_pkg::COUNT_W-1:0]      used_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fbfl_pkg::*;

  localparam int CAP = (NUM_BLOCKS < MAX_COUNT) ? NUM_BLOCKS : MAX_COUNT;
  localparam int AW  = $clog2(CAP);
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP);

  // config registers
  logic [COUNT_W-1:0] block_count;
  logic [SIZE_W-1:0]  block_size;
  logic [ADDR_W-1:0]  base_address;
  logic [COUNT_W-1:0] count_wdata;
  logic               count_wr;

  // list state
  logic [LINK_W-1:0]  head;
  logic [COUNT_W-1:0] used_blocks, used_next;
  logic [AW-1:0]      clr_idx;
  logic               clr_last;
  logic [LINK_W-1:0]  clr_data;

  // item in flight
  logic               p_mode;
  status_t            p_status;
  logic [INDEX_W-1:0] p_idx;
  logic [PROD_W-1:0]  prod;

  // accept-cycle decode
  logic               alloc_empty, free_bad;
  logic [INDEX_W-1:0] idx_sel;
  status_t            status_sel;

  // link RAM ports
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [LINK_W-1:0]  ram_wdata, ram_rdata;

  // result register
  status_t            rsp_status;

  assign cfg_ready = 1'b1;
  assign count_wr  = cfg_valid && (cfg_index == REG_BLOCK_COUNT);

  always_comb begin
    count_wdata = cfg_data[COUNT_W-1:0];
    if (count_wdata == '0) begin
      count_wdata = COUNT_W'(1);
    end else if (count_wdata > COUNT_CAP) begin
      count_wdata = COUNT_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count  <= COUNT_CAP;
      block_size   <= SIZE_RST;
      base_address <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT:  block_count  <= count_wdata;
        REG_BLOCK_SIZE:   block_size   <= cfg_data[SIZE_W-1:0];
        REG_BASE_ADDRESS: base_address <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // rebuild pass: entry i links to i+1, entry block_count-1 gets the end marker
  assign clr_last = ({{(COUNT_W-AW){1'b0}}, clr_idx} == (block_count - COUNT_W'(1)));
  assign clr_data = clr_last ? END_MARK : ({{(LINK_W-AW){1'b0}}, clr_idx} + LINK_W'(1));

  // head and count share one width
  assign alloc_empty = (head >= block_count);
  assign free_bad    = ({{(COUNT_W-INDEX_W){1'b0}}, free_index} >= block_count);

  always_comb begin
    if (mode) begin
      idx_sel    = free_index;
      status_sel = free_bad ? STATUS_RANGE : STATUS_OK;
    end else begin
      idx_sel    = alloc_empty ? '0 : head[INDEX_W-1:0];
      status_sel = alloc_empty ? STATUS_EMPTY : STATUS_OK;
    end
  end

  always_comb begin
    ram_re    = cmd.accept && !mode && !alloc_empty;
    ram_raddr = head[AW-1:0];
    if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = clr_data;
    end else begin
      // free pushes onto the head: new entry links to the old head
      ram_we    = cmd.accept && mode && !free_bad;
      ram_waddr = free_index[AW-1:0];
      ram_wdata = head;
    end
  end

  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAP)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_mode   <= mode;
      p_status <= status_sel;
      p_idx    <= idx_sel;
      prod     <= {{SIZE_W{1'b0}}, idx_sel} * {{INDEX_W{1'b0}}, block_size};
    end
  end

  always_comb begin
    used_next = used_blocks;
    if (p_status == STATUS_OK) begin
      if (!p_mode && (used_blocks != USED_MAX)) begin
        used_next = used_blocks + COUNT_W'(1);
      end else if (p_mode && (used_blocks != '0)) begin
        used_next = used_blocks - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      used_blocks <= '0;
      clr_idx     <= '0;
    end else if (count_wr) begin
      head        <= '0;
      used_blocks <= '0;
      clr_idx     <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (cmd.exec_done) begin
        used_blocks <= used_next;
        if (p_status == STATUS_OK) begin
          head <= p_mode ? {{(LINK_W-INDEX_W){1'b0}}, p_idx} : ram_rdata;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_done) begin
      rsp_status  <= p_status;
      block_index <= p_idx;
      address     <= (p_status == STATUS_OK) ?
                     base_address + {{(ADDR_W-PROD_W){1'b0}}, prod} : '0;
      used_count  <= used_next;
    end
  end

  assign status = rsp_status;

  assign sts.count_wr = count_wr;
  assign sts.clr_last = clr_last;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  a_clr_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_write |-> !cmd.accept)
    else $error("item accepted during list rebuild");

  a_head_sane: assert property (@(posedge clk) disable iff (rst)
    (head < block_count) || (head == END_MARK))
    else $error("head points outside the pool");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.exec_done |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten while held");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_block_free_list_allocator: an in-bench pool model
// predicts every reply; depends on fbfl_pkg and the allocator RTL only.
module testbench;
  import fbfl_pkg::*;

  localparam int POOL_DEPTH = NUM_BLOCKS_DEF;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int TARGET_REQS  = 1050;
  localparam int STEADY_PHASE = 2;
  localparam int HOLD_PHASE   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 36;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] index;
  } pool_req_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] used;
  } pool_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  mode = 1'b0;
  logic [INDEX_W-1:0]    free_index = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [1:0]            status;
  logic [INDEX_W-1:0]    block_index;
  logic [ADDR_W-1:0]     address;
  logic [COUNT_W-1:0]    used_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // pool model state and registers
  logic [LINK_W-1:0]  pool_link [POOL_DEPTH];
  logic [LINK_W-1:0]  pool_head;
  logic [COUNT_W-1:0] pool_used;
  logic [COUNT_W-1:0] pool_cnt;
  logic [SIZE_W-1:0]  pool_size;
  logic [ADDR_W-1:0]  pool_base;

  pool_req_t   pending_reqs [$];
  pool_reply_t due_replies [$];
  int          free_stack [$];
  int          held_blocks [$];

  logic steady = 1'b0;
  logic want_hold = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  pool_req_t next_req;

  int planned = 0;
  int mismatches = 0;
  int n_alloc = 0, n_free = 0, n_empty = 0, n_range = 0;
  int cfg_writes = 0, replies_seen = 0, phases = 0;

  fixed_block_free_list_allocator DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .free_index(free_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .block_index(block_index),
    .address(address), .used_count(used_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void rebuild_pool();
    for (int i = 0; i < POOL_DEPTH; i++) pool_link[i] = LINK_W'(i + 1);
    pool_link[pool_cnt - 1] = END_MARK;
    pool_head = '0;
    pool_used = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BLOCK_COUNT: begin
        if (data[COUNT_W-1:0] == 0) pool_cnt = COUNT_W'(1);
        else if (data[COUNT_W-1:0] > MAX_COUNT) pool_cnt = COUNT_W'(MAX_COUNT);
        else pool_cnt = data[COUNT_W-1:0];
        rebuild_pool();
      end
      REG_BLOCK_SIZE:   pool_size = data[SIZE_W-1:0];
      REG_BASE_ADDRESS: pool_base = data;
      default: ;
    endcase
  endfunction

  function automatic void predict_reply(logic op, logic [INDEX_W-1:0] fi);
    pool_reply_t r;
    r = '0;
    r.status = STATUS_OK;
    if (op == MODE_ALLOC) begin
      n_alloc++;
      if (pool_head >= pool_cnt || pool_head >= POOL_DEPTH) begin
        r.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        r.index = pool_head[INDEX_W-1:0];
        r.addr = pool_base + 32'(r.index) * 32'(pool_size);
        pool_head = pool_link[r.index];
        if (pool_used != USED_MAX) pool_used++;
      end
    end else begin
      n_free++;
      r.index = fi;
      if (COUNT_W'(fi) >= pool_cnt) begin
        r.status = STATUS_RANGE;
        n_range++;
      end else begin
        r.addr = pool_base + 32'(fi) * 32'(pool_size);
        pool_link[fi] = pool_head;
        pool_head = LINK_W'(fi);
        if (pool_used != 0) pool_used--;
      end
    end
    r.used = pool_used;
    due_replies.push_back(r);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_req(logic op, logic [INDEX_W-1:0] idx);
    pool_req_t q;
    q.op = op;
    q.index = idx;
    pending_reqs.push_back(q);
    planned++;
  endtask

  // Mostly well-formed traffic: frees return blocks picked at random from those
  // held; noise is out-of-range frees and, near the phase end, maybe double frees.
  task automatic plan_phase(int n);
    int r, j, idx;
    free_stack.delete();
    held_blocks.delete();
    for (int i = 0; i < pool_cnt; i++) free_stack.push_back(i);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30 && held_blocks.size() > 0) begin
        j = $urandom_range(held_blocks.size() - 1);
        idx = held_blocks[j];
        held_blocks.delete(j);
        free_stack.push_front(idx);
        queue_req(MODE_FREE, INDEX_W'(idx));
      end else if (r >= 30 && r < 38 && pool_cnt < MAX_COUNT) begin
        queue_req(MODE_FREE, INDEX_W'($urandom_range(POOL_DEPTH - 1, pool_cnt)));
      end else if (r >= 38 && r < 42 && k >= n - 4) begin
        queue_req(MODE_FREE, INDEX_W'($urandom_range(pool_cnt - 1)));
      end else begin
        if (free_stack.size() > 0) held_blocks.push_back(free_stack.pop_front());
        queue_req(MODE_ALLOC, INDEX_W'($urandom));
      end
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // checked at the falling edge so all of the rising-edge updates have landed
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || due_replies.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) predict_reply(mode, free_index);
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = pending_reqs.pop_front();
          req_valid <= 1'b1;
          mode <= next_req.op;
          free_index <= next_req.index;
        end else begin
          req_valid <= 1'b0;
          mode <= 1'($urandom);
          free_index <= INDEX_W'($urandom);
        end
      end
    end
  end

  // reply monitor and stall generator
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        replies_seen++;
        if (due_replies.size() == 0) begin
          $display("%0t: reply mismatch, expected no reply got index %0d",
                   $time, block_index);
          mismatches++;
        end else begin
          check_field("status", 32'(due_replies[0].status), 32'(status));
          check_field("block_index", 32'(due_replies[0].index), 32'(block_index));
          check_field("address", due_replies[0].addr, address);
          check_field("used_count", 32'(due_replies[0].used), 32'(used_count));
          void'(due_replies.pop_front());
        end
      end
      if (want_hold && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int sel, n;
    logic [CFG_DATA_W-1:0] cnt_val, size_val;
    pool_cnt = COUNT_W'(MAX_COUNT);
    pool_size = SIZE_RST;
    pool_base = '0;
    rebuild_pool();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: 1024 blocks, stride 64, base 0
    queue_req(MODE_FREE, 10'd5);      // free with nothing held, count stays at zero
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_FREE, 10'd1023);
    queue_req(MODE_ALLOC, 10'h3FF);
    drain();

    cfg_write(REG_BLOCK_COUNT, 32'd0);  // taken as one block
    cfg_write(REG_BLOCK_SIZE, 32'd65536);
    cfg_write(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
    cfg_write(REG_UNUSED, 32'hA5A5_5A5A);
    @(negedge clk);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_ALLOC, 10'd0);     // empty pool
    queue_req(MODE_FREE, 10'd1);      // out of range
    queue_req(MODE_FREE, 10'd1023);
    queue_req(MODE_FREE, 10'd0);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_FREE, 10'd0);
    queue_req(MODE_FREE, 10'd0);      // double free links the block to itself
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_ALLOC, 10'd0);
    drain();

    cfg_write(REG_BLOCK_COUNT, 32'd2047);  // clamped to the pool limit
    cfg_write(REG_BLOCK_SIZE, 32'h1_FFFF);
    cfg_write(REG_BASE_ADDRESS, 32'hFFFF_F000);
    @(negedge clk);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_FREE, 10'd1023);
    queue_req(MODE_ALLOC, 10'd0);
    queue_req(MODE_FREE, 10'd0);
    drain();

    while (planned < TARGET_REQS) begin
      sel = $urandom_range(9);
      case (sel)
        0: size_val = 32'd1;
        1: size_val = 32'h1_FFFF;
        2: size_val = 32'd65536;
        default: size_val = 32'($urandom_range(32'h1_FFFF, 1));
      endcase
      cfg_write(REG_BLOCK_SIZE, size_val);
      cfg_write(REG_BASE_ADDRESS, $urandom);
      if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, $urandom);
      sel = $urandom_range(9);
      case (sel)
        0: cnt_val = 32'd1024;
        1: cnt_val = $urandom;            // upper bits are dropped by the register
        2: cnt_val = 32'($urandom_range(2047, 1025));
        3: cnt_val = 32'($urandom_range(1024, 1));
        default: cnt_val = 32'($urandom_range(24, 1));
      endcase
      if (phases == HOLD_PHASE) cnt_val = 32'd1024;
      cfg_write(REG_BLOCK_COUNT, cnt_val);
      n = (phases == HOLD_PHASE) ? 200 : $urandom_range(120, 30);
      @(negedge clk);
      steady = (phases == STEADY_PHASE);
      want_hold = (phases == HOLD_PHASE);
      plan_phase(n);
      drain();
      steady = 1'b0;
      want_hold = 1'b0;
      phases++;
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d items: %0d allocations (%0d on an empty pool), %0d frees (%0d out of range)",
             planned, n_alloc, n_empty, n_free, n_range);
    $display("%0d register writes over %0d random phases, %0d replies checked",
             cfg_writes, phases, replies_seen);
    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d items queued and %0d replies outstanding",
             pending_reqs.size(), due_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> fixed_block_free_list_allocator.f
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_ram.sv
hw/rtl/fbfl_ctrl.sv
hw/rtl/fbfl_dpath.sv
hw/rtl/fixed_block_free_list_allocator.sv
tb/testbench.sv
